/* rtl/bcr_pkg.sv */
// ----------------------------------------------------------------------------
// bcr_pkg
// shared types and constants for the midpoint circle rasterizer
// ----------------------------------------------------------------------------
package bcr_pkg;

  localparam int CENTER_W    = 12;
  localparam int RADIUS_W    = 11;
  localparam int STEP_X_W    = 12;
  localparam int STEP_Y_W    = 13;
  localparam int DEC_W       = 16;
  localparam int PIX_W       = 14;
  localparam int COORD_BITS_DEF = 12;

  localparam int POINTS_PER_STEP = 8;
  localparam int IDX_W           = $clog2(POINTS_PER_STEP);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINTS_PER_STEP - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // decision variable constants
  localparam logic signed [DEC_W-1:0] DEC_INIT     = DEC_W'(3);
  localparam logic signed [DEC_W-1:0] DEC_INC_HOLD = DEC_W'(6);
  localparam logic signed [DEC_W-1:0] DEC_INC_MOVE = DEC_W'(10);

  typedef enum logic {
    MODE_START   = 1'b0,
    MODE_ADVANCE = 1'b1
  } mode_e;

  // one step of work handed from front to back
  typedef struct packed {
    logic                is_done;
    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;
    logic [STEP_X_W-1:0] x;
    logic [STEP_Y_W-1:0] y;
  } cmd_t;

endpackage

/* rtl/bcr_front.sv */
// ----------------------------------------------------------------------------
// bcr_front
// accepts start / advance words, keeps the octant walk, issues step commands
// ----------------------------------------------------------------------------
module bcr_front
  import bcr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [CENTER_W-1:0] center_x_i,
  input  logic [CENTER_W-1:0] center_y_i,
  input  logic [RADIUS_W-1:0] radius_i,
  output logic                push_o,
  output cmd_t                push_cmd_o,
  input  logic                q_full_i
);

  localparam logic [CENTER_W-1:0] CenterMask =
    (COORD_BITS >= CENTER_W) ? {CENTER_W{1'b1}} : CENTER_W'((1 << COORD_BITS) - 1);

  logic [STEP_X_W-1:0]        step_x_q, step_x_d;
  logic signed [STEP_Y_W-1:0] step_y_q, step_y_d;
  logic signed [DEC_W-1:0]    dec_q, dec_d;
  logic [CENTER_W-1:0]        cx_q, cx_d, cy_q, cy_d;
  logic                       drawing_q, drawing_d;

  logic                       accept;
  logic                       is_start;
  logic                       walk_ok;
  logic [STEP_X_W-1:0]        x_cur;
  logic signed [STEP_Y_W-1:0] y_cur;
  logic signed [DEC_W-1:0]    d_cur;
  logic signed [DEC_W-1:0]    d_inc;
  logic signed [PIX_W-1:0]    x_ext, y_ext, xy_diff;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_start   = (mode_e'(mode_i) == MODE_START);

  // x <= y, signed compare on the stored walk
  assign walk_ok = drawing_q &&
    ($signed({{(PIX_W-STEP_X_W){1'b0}}, step_x_q}) <=
     $signed({{(PIX_W-STEP_Y_W){step_y_q[STEP_Y_W-1]}}, step_y_q}));

  always_comb begin
    x_cur = is_start ? '0 : step_x_q;
    y_cur = is_start ? $signed({{(STEP_Y_W-RADIUS_W){1'b0}}, radius_i}) : step_y_q;
    d_cur = is_start
      ? DEC_INIT - $signed({{(DEC_W-RADIUS_W-1){1'b0}}, radius_i, 1'b0})
      : dec_q;
    x_ext   = $signed({{(PIX_W-STEP_X_W){1'b0}}, x_cur});
    y_ext   = $signed({{(PIX_W-STEP_Y_W){y_cur[STEP_Y_W-1]}}, y_cur});
    xy_diff = x_ext - y_ext;
    if (d_cur[DEC_W-1]) begin
      d_inc = $signed({{(DEC_W-PIX_W){1'b0}}, x_ext[PIX_W-3:0], 2'b00}) + DEC_INC_HOLD;
    end else begin
      d_inc = $signed({{(DEC_W-PIX_W){xy_diff[PIX_W-1]}}, xy_diff[PIX_W-3:0], 2'b00})
              + DEC_INC_MOVE;
    end
  end

  always_comb begin
    step_x_d  = step_x_q;
    step_y_d  = step_y_q;
    dec_d     = dec_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    drawing_d = drawing_q;

    push_cmd_o.is_done = 1'b0;
    push_cmd_o.cx      = is_start ? (center_x_i & CenterMask) : cx_q;
    push_cmd_o.cy      = is_start ? (center_y_i & CenterMask) : cy_q;
    push_cmd_o.x       = x_cur;
    push_cmd_o.y       = y_cur;

    if (accept) begin
      if (is_start || walk_ok) begin
        cx_d      = push_cmd_o.cx;
        cy_d      = push_cmd_o.cy;
        drawing_d = 1'b1;
        dec_d     = d_cur + d_inc;
        step_y_d  = d_cur[DEC_W-1] ? y_cur : y_cur - STEP_Y_W'(1);
        step_x_d  = x_cur + STEP_X_W'(1);
      end else begin
        drawing_d          = 1'b0;
        push_cmd_o.is_done = 1'b1;
      end
    end
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q  <= '0;
      step_y_q  <= '0;
      dec_q     <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      drawing_q <= 1'b0;
    end else begin
      step_x_q  <= step_x_d;
      step_y_q  <= step_y_d;
      dec_q     <= dec_d;
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      drawing_q <= drawing_d;
    end
  end

endmodule

/* rtl/bcr_queue.sv */
// ----------------------------------------------------------------------------
// bcr_queue
// short command fifo between front and back
// ----------------------------------------------------------------------------
module bcr_queue
  import bcr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/bcr_back.sv */
// ----------------------------------------------------------------------------
// bcr_back
// expands a step into its eight symmetric points, one per cycle unless stalled
// ----------------------------------------------------------------------------
module bcr_back
  import bcr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  cmd_t                    q_cmd_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [PIX_W-1:0] pixel_x_o,
  output logic signed [PIX_W-1:0] pixel_y_o,
  output logic                    last_of_step_o,
  output logic                    circle_done_o
);

  cmd_t                    cmd_q;
  logic                    active_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    out_valid_q;
  logic signed [PIX_W-1:0] px_q, py_q, px_d, py_d;
  logic                    last_q, done_q, last_d;

  logic                    out_free, issue, last_issue;
  logic signed [PIX_W-1:0] cx_e, cy_e, x_e, y_e, a_e, b_e;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign issue      = active_q && out_free;
  assign last_issue = issue && (cmd_q.is_done || idx_q == IDX_LAST);
  assign pop_o      = q_valid_i && (!active_q || last_issue);

  always_comb begin
    cx_e = $signed({{(PIX_W-CENTER_W){1'b0}}, cmd_q.cx});
    cy_e = $signed({{(PIX_W-CENTER_W){1'b0}}, cmd_q.cy});
    x_e  = $signed({{(PIX_W-STEP_X_W){1'b0}}, cmd_q.x});
    y_e  = $signed({{(PIX_W-STEP_Y_W){cmd_q.y[STEP_Y_W-1]}}, cmd_q.y});
    // upper half of the step swaps x and y
    a_e  = idx_q[2] ? y_e : x_e;
    b_e  = idx_q[2] ? x_e : y_e;
    if (cmd_q.is_done) begin
      px_d   = '0;
      py_d   = '0;
      last_d = 1'b1;
    end else begin
      px_d   = idx_q[0] ? cx_e - a_e : cx_e + a_e;
      py_d   = idx_q[1] ? cy_e - b_e : cy_e + b_e;
      last_d = (idx_q == IDX_LAST);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_cmd_i;
    end
    if (issue) begin
      px_q   <= px_d;
      py_q   <= py_d;
      last_q <= last_d;
      done_q <= cmd_q.is_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (last_issue) begin
        active_q <= 1'b0;
      end else if (issue) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

endmodule

/* rtl/bresenham_circle_rasterizer.sv */
// ----------------------------------------------------------------------------
// bresenham_circle_rasterizer
// midpoint circle rasterizer with eight-way symmetry
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) takes one word per accepted edge;
//   mode 0 starts a circle at center_x/center_y with radius, mode 1 advances
//   the octant walk by one step
//   output channel (out_valid_o / out_stall_i) gives eight point words per
//   step, last_of_step_o high on the eighth; an advance after the walk has
//   crossed the diagonal (or with no circle active) gives one word with
//   circle_done_o and last_of_step_o high and zero coordinates
// path: an accepted word is written into the command queue, then popped
//   into the back end's command register and sent out from the output register
// throughput: the back end puts out one point per cycle while the output is
//   not stalled; the front keeps taking words back to back until the
//   two-entry command queue fills
// reset: clears the walk state (no circle active), empties the queue and
//   drops any pending output word
// stall: a stalled output word holds; the back end stops, the queue fills,
//   and then in_stall_o rises
// ----------------------------------------------------------------------------
module bresenham_circle_rasterizer
  import bcr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    mode_i,
  input  logic [CENTER_W-1:0]     center_x_i,
  input  logic [CENTER_W-1:0]     center_y_i,
  input  logic [RADIUS_W-1:0]     radius_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [PIX_W-1:0] pixel_x_o,
  output logic signed [PIX_W-1:0] pixel_y_o,
  output logic                    last_of_step_o,
  output logic                    circle_done_o
);

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // queue to back
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  // front: classifies each word and advances the walk at accept time
  bcr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .q_full_i   (q_full)
  );

  // decouples the walk from point output
  bcr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd),
    .pop_i      (pop)
  );

  // back: one symmetric point per cycle into the output register unless stalled
  bcr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

endmodule
